// ----- hw/rtl/ncz_pkg.sv -----
// ncz_pkg: types, constants and coefficient tables for the normal cdf / critical z block.
// No dependencies.
`default_nettype none
package ncz_pkg;

    localparam int QB    = 30;
    localparam int ACC_W = 34;
    localparam int BIS_W = 34;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Coefficient in units of 1e-12, rounded to nearest Q30.
    function automatic longint to_q(input longint c);
        longint m;
        longint r;
        m = (c < 0) ? -c : c;
        r = (m * 64'sd262144 + 64'sd122070312) / 64'sd244140625;
        return (c < 0) ? -r : r;
    endfunction

    localparam t_acc C_LOW [0:8] = '{
        t_acc'(to_q(64'sd124818987)),     t_acc'(to_q(-64'sd1075204047)),
        t_acc'(to_q(64'sd5198775019)),    t_acc'(to_q(-64'sd19198292004)),
        t_acc'(to_q(64'sd59054035642)),   t_acc'(to_q(-64'sd151968751364)),
        t_acc'(to_q(64'sd319152932694)),  t_acc'(to_q(-64'sd531923007300)),
        t_acc'(to_q(64'sd797884560593))
    };

    localparam t_acc C_HIGH [0:14] = '{
        t_acc'(to_q(-64'sd45255659)),     t_acc'(to_q(64'sd152529290)),
        t_acc'(to_q(-64'sd19538132)),     t_acc'(to_q(-64'sd676904986)),
        t_acc'(to_q(64'sd1390604284)),    t_acc'(to_q(-64'sd794620820)),
        t_acc'(to_q(-64'sd2034254874)),   t_acc'(to_q(64'sd6549791214)),
        t_acc'(to_q(-64'sd10557625006)),  t_acc'(to_q(64'sd11630447319)),
        t_acc'(to_q(-64'sd9279453341)),   t_acc'(to_q(64'sd5353579108)),
        t_acc'(to_q(-64'sd2141268741)),   t_acc'(to_q(64'sd535310849)),
        t_acc'(to_q(64'sd999936657524))
    };

    localparam logic [3:0] LOW_LAST  = 4'd8;
    localparam logic [3:0] HIGH_LAST = 4'd14;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SETZ,
        CMD_MYY,
        CMD_WINIT,
        CMD_HINIT,
        CMD_MUL,
        CMD_ADD,
        CMD_MAY,
        CMD_X2,
        CMD_CDF,
        CMD_BIS,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic func;
        logic p_bad;
        logic mag_zero;
        logic y_ge3;
        logic y_lt1;
        logic hmode;
        logic add_last;
        logic bis_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- hw/rtl/ncz_ifs.sv -----
// ncz_ifs: valid/ready stream interfaces for the input and result channels.
// Depends on nothing.
`default_nettype none
interface ncz_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [27:0] z_value;
    logic [24:0] p_value;

    modport source (output valid, func, z_value, p_value, input ready);
    modport sink   (input valid, func, z_value, p_value, output ready);
endinterface

interface ncz_out_if;
    logic        valid;
    logic        ready;
    logic [24:0] probability;
    logic [26:0] critical_z;
    logic        p_invalid;

    modport source (output valid, probability, critical_z, p_invalid, input ready);
    modport sink   (input valid, probability, critical_z, p_invalid, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ncz_ctrl.sv -----
// ncz_ctrl: sequencing state machine for the Horner evaluation and bisection.
// Depends on ncz_pkg.
`default_nettype none
module ncz_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  ncz_pkg::t_status  i_status,
    output ncz_pkg::t_cmd     o_cmd
);
    import ncz_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LOAD  = 14'b00000000000010,
        S_DISP  = 14'b00000000000100,
        S_SETZ  = 14'b00000000001000,
        S_MYY   = 14'b00000000010000,
        S_WINIT = 14'b00000000100000,
        S_HINIT = 14'b00000001000000,
        S_MUL   = 14'b00000010000000,
        S_ADD   = 14'b00000100000000,
        S_MAY   = 14'b00001000000000,
        S_X2    = 14'b00010000000000,
        S_CDF   = 14'b00100000000000,
        S_BIS   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (i_status.func && i_status.p_bad) ? S_OUT : S_DISP;
            end
            S_DISP: begin
                priority if (i_status.mag_zero || i_status.y_ge3) begin
                    n_state = S_CDF;
                end else if (i_status.y_lt1) begin
                    n_state = S_MYY;
                end else begin
                    n_state = S_HINIT;
                end
            end
            S_SETZ: begin
                o_cmd   = CMD_SETZ;
                n_state = S_DISP;
            end
            S_MYY: begin
                o_cmd   = CMD_MYY;
                n_state = S_WINIT;
            end
            S_WINIT: begin
                o_cmd   = CMD_WINIT;
                n_state = S_MUL;
            end
            S_HINIT: begin
                o_cmd   = CMD_HINIT;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd   = CMD_MUL;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd = CMD_ADD;
                if (!i_status.add_last) begin
                    n_state = S_MUL;
                end else begin
                    n_state = i_status.hmode ? S_CDF : S_MAY;
                end
            end
            S_MAY: begin
                o_cmd   = CMD_MAY;
                n_state = S_X2;
            end
            S_X2: begin
                o_cmd   = CMD_X2;
                n_state = S_CDF;
            end
            S_CDF: begin
                o_cmd   = CMD_CDF;
                n_state = i_status.func ? S_BIS : S_OUT;
            end
            S_BIS: begin
                o_cmd   = CMD_BIS;
                n_state = i_status.bis_last ? S_OUT : S_SETZ;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ncz_dp.sv -----
// ncz_dp: datapath with the shared Q30 multiplier, Horner accumulator,
// bisection bounds and the result register. Depends on ncz_pkg.
`default_nettype none
module ncz_dp #(
    parameter int FRAC_BITS    = 24,
    parameter int BISECT_STEPS = 24
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ncz_pkg::t_cmd     i_cmd,
    output ncz_pkg::t_status  o_status,
    input  wire               i_func,
    input  wire        [27:0] i_z_value,
    input  wire        [24:0] i_p_value,
    output logic              o_valid,
    input  wire               i_ready,
    output logic       [24:0] o_probability,
    output logic       [26:0] o_critical_z,
    output logic              o_p_invalid
);
    import ncz_pkg::*;

    localparam int MAG_W = ((58 - FRAC_BITS) > BIS_W) ? (58 - FRAC_BITS) : BIS_W;
    localparam int CNT_W = $clog2(BISECT_STEPS);
    localparam int SP    = 31 - FRAC_BITS;
    localparam int SC    = QB - FRAC_BITS;
    localparam logic [32:0] HALF_P = 33'd1 << (SP - 1);
    localparam logic [34:0] HALF_C = (SC > 0) ? (35'd1 << ((SC > 0) ? SC - 1 : 0)) : 35'd0;
    localparam logic [MAG_W-1:0] Y1 = MAG_W'(64'd1 << QB);
    localparam logic [MAG_W-1:0] Y3 = MAG_W'(64'd3 << QB);
    localparam logic [BIS_W-1:0] OFF = BIS_W'(64'd6 << QB);
    localparam logic [BIS_W-1:0] TOP = BIS_W'(64'd12 << QB);
    localparam t_acc ONE_A = t_acc'(64'd1 << QB);
    localparam t_acc TWO_A = t_acc'(64'd2 << QB);
    localparam logic [31:0] ONE_D = 32'd1 << QB;
    localparam logic [63:0] HALF_R = 64'd1 << (QB - 1);
    localparam logic [24:0] P_LIM = (FRAC_BITS >= 25) ? 25'h1FFFFFF : 25'(64'd1 << FRAC_BITS);

    logic             r_func, r_pbad, r_neg, r_hmode, r_pneg;
    logic [31:0]      r_p31, r_d;
    logic [MAG_W-1:0] r_mag;
    logic [BIS_W-1:0] r_lo, r_hi, r_mid;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_ci;
    t_acc             r_v, r_acc;
    logic [63:0]      r_prod;
    logic             r_ov;
    logic [24:0]      r_prob;
    logic [26:0]      r_crit;
    logic             r_pinv;

    logic [MAG_W-1:0] y;
    logic             y_ge3, y_lt1, mag_zero, p_bad_in;
    t_acc             acc_abs, v_abs, rnd_mag, rnd_s, coef, x_raw, x_cl;
    logic [31:0]      mul_a, mul_b, d_new;
    logic [27:0]      z_mag;
    logic [BIS_W-1:0] lo_new, hi_new, mid_new, m_abs;
    logic [BIS_W:0]   bis_sum;
    logic             mid_neg;

    assign y        = r_mag >> 1;
    assign y_ge3    = (y >= Y3);
    assign y_lt1    = (y < Y1);
    assign mag_zero = (r_mag == '0);
    assign acc_abs  = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign v_abs    = r_v[ACC_W-1] ? -r_v : r_v;
    assign rnd_mag  = t_acc'((r_prod + HALF_R) >> QB);
    assign rnd_s    = r_pneg ? -rnd_mag : rnd_mag;
    assign coef     = r_hmode ? C_HIGH[r_ci] : ((r_ci <= LOW_LAST) ? C_LOW[r_ci] : '0);
    assign z_mag    = i_z_value[27] ? (28'd0 - i_z_value) : i_z_value;
    assign p_bad_in = (i_p_value == '0) || (i_p_value >= P_LIM);
    assign mid_neg  = (r_mid < OFF);
    assign m_abs    = mid_neg ? (OFF - r_mid) : (r_mid - OFF);

    always_comb begin
        unique case (i_cmd)
            CMD_MYY: begin
                mul_a = y[31:0];
                mul_b = y[31:0];
            end
            CMD_MUL: begin
                mul_a = acc_abs[31:0];
                mul_b = v_abs[31:0];
            end
            CMD_MAY: begin
                mul_a = acc_abs[31:0];
                mul_b = y[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        x_raw = y_ge3 ? ONE_A : r_acc;
        priority if (x_raw[ACC_W-1]) begin
            x_cl = '0;
        end else if (x_raw > ONE_A) begin
            x_cl = ONE_A;
        end else begin
            x_cl = x_raw;
        end
        priority if (mag_zero) begin
            d_new = ONE_D;
        end else if (r_neg) begin
            d_new = ONE_D - x_cl[31:0];
        end else begin
            d_new = ONE_D + x_cl[31:0];
        end
    end

    always_comb begin
        if (r_d > r_p31) begin
            hi_new = r_mid;
            lo_new = r_lo;
        end else begin
            hi_new = r_hi;
            lo_new = r_mid;
        end
        bis_sum = {1'b0, lo_new} + {1'b0, hi_new};
        mid_new = bis_sum[BIS_W:1];
    end

    always_comb begin
        o_status.func     = r_func;
        o_status.p_bad    = r_pbad;
        o_status.mag_zero = mag_zero;
        o_status.y_ge3    = y_ge3;
        o_status.y_lt1    = y_lt1;
        o_status.hmode    = r_hmode;
        o_status.add_last = r_hmode ? (r_ci == HIGH_LAST) : (r_ci == LOW_LAST);
        o_status.bis_last = (r_cnt == CNT_W'(BISECT_STEPS - 1));
        o_status.out_free = !r_ov || i_ready;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_func <= i_func;
                r_pbad <= p_bad_in;
                r_p31  <= 32'({7'd0, i_p_value} << SP);
                r_lo   <= '0;
                r_hi   <= TOP;
                r_mid  <= OFF;
                r_cnt  <= '0;
                if (i_func) begin
                    r_neg <= 1'b0;
                    r_mag <= '0;
                end else begin
                    r_neg <= i_z_value[27];
                    r_mag <= MAG_W'(z_mag) << SC;
                end
            end
            CMD_SETZ: begin
                r_neg <= mid_neg;
                r_mag <= MAG_W'(m_abs);
            end
            CMD_MYY: begin
                r_prod <= mul_a * mul_b;
                r_pneg <= 1'b0;
            end
            CMD_WINIT: begin
                r_v     <= rnd_s;
                r_acc   <= C_LOW[0];
                r_ci    <= 4'd1;
                r_hmode <= 1'b0;
            end
            CMD_HINIT: begin
                r_v     <= t_acc'({2'b00, y[31:0]}) - TWO_A;
                r_acc   <= C_HIGH[0];
                r_ci    <= 4'd1;
                r_hmode <= 1'b1;
            end
            CMD_MUL: begin
                r_prod <= mul_a * mul_b;
                r_pneg <= r_acc[ACC_W-1] ^ r_v[ACC_W-1];
            end
            CMD_ADD: begin
                r_acc <= rnd_s + coef;
                r_ci  <= r_ci + 4'd1;
            end
            CMD_MAY: begin
                r_prod <= mul_a * mul_b;
                r_pneg <= r_acc[ACC_W-1];
            end
            CMD_X2: begin
                r_acc <= rnd_s <<< 1;
            end
            CMD_CDF: begin
                r_d <= d_new;
            end
            CMD_BIS: begin
                r_lo  <= lo_new;
                r_hi  <= hi_new;
                r_mid <= mid_new;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            CMD_OUT: begin
                if (!r_func) begin
                    r_prob <= 25'(({1'b0, r_d} + HALF_P) >> SP);
                    r_crit <= '0;
                    r_pinv <= 1'b0;
                end else if (r_pbad) begin
                    r_prob <= '0;
                    r_crit <= '0;
                    r_pinv <= 1'b1;
                end else begin
                    r_prob <= '0;
                    r_crit <= 27'(({1'b0, m_abs} + HALF_C) >> SC);
                    r_pinv <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd == CMD_OUT) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid       = r_ov;
    assign o_probability = r_prob;
    assign o_critical_z  = r_crit;
    assign o_p_invalid   = r_pinv;

endmodule
`default_nettype wire

// ----- hw/rtl/normal_cdf_and_critical_z.sv -----
// cdf item: low polynomial (|z|/2 < 1) or high polynomial (1 <= |z|/2 < 3), none
// when saturated or z = 0; critical z item: BISECT_STEPS bisection steps; invalid p
// goes straight to the result. Input is ready again once the result registers.
// One item at a time; each Horner step is a multiply and an add using the single
// shared 32x32 multiplier. Result register frees input during stall.
// Reset: synchronous active-low i_rst_n returns to idle, result register empty.
`default_nettype none
module normal_cdf_and_critical_z #(
    parameter int FRAC_BITS    = 24,
    parameter int BISECT_STEPS = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ncz_in_if.sink      i_in,
    ncz_out_if.source   o_out
);
    import ncz_pkg::*;

    t_cmd    cmd;
    t_status status;

    ncz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ncz_dp #(
        .FRAC_BITS    (FRAC_BITS),
        .BISECT_STEPS (BISECT_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (i_in.func),
        .i_z_value     (i_in.z_value),
        .i_p_value     (i_in.p_value),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_probability (o_out.probability),
        .o_critical_z  (o_out.critical_z),
        .o_p_invalid   (o_out.p_invalid)
    );

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for normal_cdf_and_critical_z (normal cdf and critical z).
// Depends on ncz_pkg, ncz_ifs and the block RTL; predicts each result in-bench.
`timescale 1ns / 100ps
module tb;
    import ncz_pkg::*;

    localparam int FRAC     = 24;
    localparam int STEPS    = 24;
    localparam int N_RAND   = 1150;
    localparam int WD_LIMIT = 20000;
    localparam int HOLD_LEN = 3000;
    localparam logic FN_CDF  = 1'b0;
    localparam logic FN_CRIT = 1'b1;
    localparam longint ONE_Q = 64'sd1 << 30;

    typedef struct packed {
        logic        func;
        logic [27:0] z_value;
        logic [24:0] p_value;
    } t_req;

    typedef struct packed {
        logic [24:0] probability;
        logic [26:0] critical_z;
        logic        p_invalid;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    ncz_in_if  in_ch ();
    ncz_out_if out_ch ();

    normal_cdf_and_critical_z #(.FRAC_BITS(FRAC), .BISECT_STEPS(STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    t_req pending_q[$];
    t_res expected_q[$];
    int   n_fail;
    int   idle_cycles;
    bit   hold_off;
    bit   in_acc;

    // Coefficients in 1e-12, highest degree first.
    longint low_c[0:8] = '{64'sd124818987, -64'sd1075204047, 64'sd5198775019,
        -64'sd19198292004, 64'sd59054035642, -64'sd151968751364, 64'sd319152932694,
        -64'sd531923007300, 64'sd797884560593};
    longint high_c[0:14] = '{-64'sd45255659, 64'sd152529290, -64'sd19538132,
        -64'sd676904986, 64'sd1390604284, -64'sd794620820, -64'sd2034254874,
        64'sd6549791214, -64'sd10557625006, 64'sd11630447319, -64'sd9279453341,
        64'sd5353579108, -64'sd2141268741, 64'sd535310849, 64'sd999936657524};

    function automatic longint coef_q30(input longint c);
        longint m;
        m = (c < 0) ? -c : c;
        m = (m * 262144 + 122070312) / 244140625;
        return (c < 0) ? -m : m;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        longint ma;
        longint mb;
        longint r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r  = (ma * mb + (ONE_Q >>> 1)) >>> 30;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint poly_low(input longint v);
        longint acc;
        acc = coef_q30(low_c[0]);
        for (int i = 1; i < 9; i++) acc = mul_q30(acc, v) + coef_q30(low_c[i]);
        return acc;
    endfunction

    function automatic longint poly_high(input longint v);
        longint acc;
        acc = coef_q30(high_c[0]);
        for (int i = 1; i < 15; i++) acc = mul_q30(acc, v) + coef_q30(high_c[i]);
        return acc;
    endfunction

    // Twice the cdf in Q30 for sign and Q30 magnitude.
    function automatic longint cdf_x2(input bit neg, input longint mag);
        longint y;
        longint x;
        if (mag == 0) return ONE_Q;
        y = mag >>> 1;
        if (y >= 3 * ONE_Q) x = ONE_Q;
        else if (y < ONE_Q) x = 2 * mul_q30(poly_low(mul_q30(y, y)), y);
        else x = poly_high(y - 2 * ONE_Q);
        if (x < 0) x = 0;
        if (x > ONE_Q) x = ONE_Q;
        return neg ? ONE_Q - x : ONE_Q + x;
    endfunction

    function automatic t_res normal_result(input t_req r);
        t_res   o;
        longint v;
        longint mag;
        longint p31;
        longint lo;
        longint hi;
        longint mid;
        bit     neg;
        o = '0;
        if (r.func == FN_CDF) begin
            v   = longint'(r.z_value);
            neg = r.z_value[27];
            mag = neg ? (longint'(1) <<< 28) - v : v;
            o.probability = 25'((cdf_x2(neg, mag <<< 6) + 64) >>> 7);
        end else if (r.p_value == 0 || r.p_value >= 25'(1 << FRAC)) begin
            o.p_invalid = 1'b1;
        end else begin
            p31 = longint'(r.p_value) <<< 7;
            lo  = 0;
            hi  = 12 * ONE_Q;
            mid = 6 * ONE_Q;
            for (int k = 0; k < STEPS; k++) begin
                neg = mid < 6 * ONE_Q;
                mag = neg ? 6 * ONE_Q - mid : mid - 6 * ONE_Q;
                if (cdf_x2(neg, mag) > p31) hi = mid;
                else lo = mid;
                mid = (lo + hi) >>> 1;
            end
            mag = (mid < 6 * ONE_Q) ? 6 * ONE_Q - mid : mid - 6 * ONE_Q;
            o.critical_z = 27'((mag + 32) >>> 6);
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_fail++;
    endtask

    function automatic t_req make_item(input logic f, input logic [27:0] z,
                                       input logic [24:0] p);
        t_req r;
        r.func = f;
        r.z_value = z;
        r.p_value = p;
        return r;
    endfunction

    function automatic t_req random_item();
        logic [27:0] z;
        logic [24:0] p;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1:    z = 28'($urandom);
            2, 3, 4: z = 28'($signed($urandom_range(0, 33554431)) - 16777216);
            default: z = 28'($signed($urandom_range(0, 201326592)) - 100663296);
        endcase
        sel = $urandom_range(0, 9);
        case (sel)
            0:       p = 25'($urandom);
            1:       p = 25'($urandom_range(0, 64));
            2:       p = 25'($urandom_range(16777150, 16777216));
            default: p = 25'($urandom_range(1, 16777215));
        endcase
        // func 1 is slow; keep it a minority
        return make_item(($urandom_range(0, 3) == 0) ? FN_CRIT : FN_CDF, z, p);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sender: bursts and gaps; in_acc flags a transfer at the last rising edge.
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (in_acc) begin
                expected_q.push_back(normal_result(pending_q.pop_front()));
            end
            if (!in_ch.valid || in_acc) begin
                if (gap_left > 0) begin
                    gap_left    <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.func    <= pending_q[0].func;
                    in_ch.z_value <= pending_q[0].z_value;
                    in_ch.p_value <= pending_q[0].p_value;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: own stall pattern, plus a long hold-off.
    int stall_mode;
    int hold_cnt;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_mode   <= 0;
            hold_cnt     <= 0;
        end else if (hold_off) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
                default: out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor and watchdog.
    t_res got;
    t_res want;
    always @(posedge i_clk) begin
        in_acc <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Watchdog expired");
                $display("Simulation FAILED");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.probability = out_ch.probability;
                got.critical_z  = out_ch.critical_z;
                got.p_invalid   = out_ch.p_invalid;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.probability !== want.probability)
                        report_mismatch("probability", got.probability, want.probability);
                    if (got.critical_z !== want.critical_z)
                        report_mismatch("critical_z", got.critical_z, want.critical_z);
                    if (got.p_invalid !== want.p_invalid)
                        report_mismatch("p_invalid", got.p_invalid, want.p_invalid);
                end
            end
        end
    end

    initial begin
        n_fail = 0;
        idle_cycles = 0;
        hold_off = 0;
        in_ch.valid = 1'b0;
        in_ch.func = FN_CDF;
        in_ch.z_value = '0;
        in_ch.p_value = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        // directed: extremes, zero, range borders, invalid p
        pending_q.push_back(make_item(FN_CDF, 28'd0, '0));
        pending_q.push_back(make_item(FN_CDF, 28'h7FFFFFF, '0));
        pending_q.push_back(make_item(FN_CDF, 28'h8000000, 25'h1FFFFFF));
        pending_q.push_back(make_item(FN_CDF, 28'(100663296), '0));
        pending_q.push_back(make_item(FN_CDF, 28'(-100663296), '0));
        pending_q.push_back(make_item(FN_CDF, 28'(33554432), '0));
        pending_q.push_back(make_item(FN_CDF, 28'(33554431), '0));
        pending_q.push_back(make_item(FN_CDF, 28'(-33554432), '0));
        pending_q.push_back(make_item(FN_CDF, 28'(100663295), '0));
        pending_q.push_back(make_item(FN_CDF, 28'd1, '0));
        pending_q.push_back(make_item(FN_CDF, 28'hFFFFFFF, '0));
        pending_q.push_back(make_item(FN_CDF, 28'(16777216), '0));
        pending_q.push_back(make_item(FN_CRIT, 28'h7FFFFFF, 25'd0));
        pending_q.push_back(make_item(FN_CRIT, '0, 25'd16777216));
        pending_q.push_back(make_item(FN_CRIT, '0, 25'h1FFFFFF));
        pending_q.push_back(make_item(FN_CRIT, '0, 25'd1));
        pending_q.push_back(make_item(FN_CRIT, '0, 25'd16777215));
        pending_q.push_back(make_item(FN_CRIT, '0, 25'd8388608));
        pending_q.push_back(make_item(FN_CRIT, '0, 25'd16358802));
        pending_q.push_back(make_item(FN_CRIT, '0, 25'd418414));
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int i = 0; i < N_RAND; i++) begin
            pending_q.push_back(random_item());
            if (i == N_RAND / 2) begin
                wait (pending_q.size() < 5);
                hold_off = 1;
                wait (hold_cnt >= HOLD_LEN);
                hold_off = 0;
            end
        end
        wait (pending_q.size() == 0 && !in_ch.valid);
        wait (expected_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_fail == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/ncz_pkg.sv
hw/rtl/ncz_ifs.sv
hw/rtl/ncz_ctrl.sv
hw/rtl/ncz_dp.sv
hw/rtl/normal_cdf_and_critical_z.sv
tb/sv/tb.sv
